FILE: hdl/tdl_pkg.sv
// ----------------------------------------------------------------------------
// tdl_pkg
// Shared codes and constants of the table-driven lexical scanner.
// ----------------------------------------------------------------------------
package tdl_pkg;

    // item opcodes
    localparam logic [2:0] OP_CHAR    = 3'd0;
    localparam logic [2:0] OP_EOL     = 3'd1;
    localparam logic [2:0] OP_TRANS   = 3'd2;
    localparam logic [2:0] OP_ATTR    = 3'd3;
    localparam logic [2:0] OP_KEYWORD = 3'd4;

    // character classes; special and limiter codes also serve as output token classes
    localparam logic [2:0] CL_SEP     = 3'd0;
    localparam logic [2:0] CL_DIGIT   = 3'd1;
    localparam logic [2:0] CL_LETTER  = 3'd2;
    localparam logic [2:0] CL_SPECIAL = 3'd3;
    localparam logic [2:0] CL_LIMITER = 3'd4;

    // token classes
    localparam logic [2:0] TK_CONST   = 3'd0;
    localparam logic [2:0] TK_KEYWORD = 3'd1;
    localparam logic [2:0] TK_IDENT   = 3'd2;

    // attribute kinds
    localparam logic [1:0] KIND_SPECIAL = 2'd1;
    localparam logic [1:0] KIND_LIMITER = 2'd2;
    localparam logic [1:0] KIND_TERM    = 2'd3;

    // DFA codes
    localparam logic [2:0] ST_ACCEPT = 3'd5;
    localparam logic [2:0] ST_DEAD   = 3'd7;

    // keyword row length and characters
    localparam int         KEY_LEN    = 16;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7a;

    // register index (paddr bit 2)
    localparam logic REG_KW_COUNT = 1'b0;
    localparam logic REG_END_COL  = 1'b1;

endpackage

FILE: hdl/table_driven_dfa_lexer.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_lexer
// Lexical scanner driven by a DFA transition table held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (i_in_valid / o_in_stall) takes load items (transition,
//  character attribute, keyword character) and source items (character,
//  end of line). Output channel (o_out_valid / i_out_stall) gives one item
//  per emitted token character, token_last set on the final one.
//  Load items leave the input ready for the next item. A source character
//  goes through a registered attribute RAM read, then a transition RAM read
//  for the DFA step. Closing a run adds the end-symbol lookup, then for
//  letter runs a keyword search over the slots and their characters
//  (keyword RAM port), then emission of each character. At reset a clearing
//  pass zeroes the transition and attribute RAMs; o_in_stall is high
//  meanwhile. Register writes over the APB port are taken at all times.
//  A stalled output holds its item; the scanner waits for the output
//  register to drain before emitting the next character.
// ----------------------------------------------------------------------------
module table_driven_dfa_lexer #(
    parameter int STATES    = 5,
    parameter int COLUMNS   = 64,
    parameter int KEY_SLOTS = 32,
    parameter int MAX_TOKEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [2:0]  i_table_row,
    input  logic [5:0]  i_table_column,
    input  logic [2:0]  i_table_next,
    input  logic [1:0]  i_char_kind,
    input  logic [4:0]  i_keyword_slot,
    input  logic [3:0]  i_keyword_pos,
    input  logic        i_keyword_end,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_token_class,
    output logic [7:0]  o_token_char,
    output logic        o_token_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TDEPTH = STATES * COLUMNS;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int CLEN   = (TDEPTH > 256) ? TDEPTH : 256;
    localparam int CCW    = $clog2(CLEN);
    localparam int KDEPTH = KEY_SLOTS * tdl_pkg::KEY_LEN;
    localparam int KAW    = $clog2(KDEPTH);
    localparam int KIW    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int TIW    = $clog2(MAX_TOKEN);
    localparam int TLW    = $clog2(MAX_TOKEN + 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ATTR, S_CHAR, S_STEP, S_CLOSE, S_ACC,
        S_KW_SLOT, S_KW_CMP, S_EMIT
    } t_state;

    t_state          r_state, n_state;
    logic [CCW-1:0]  r_clr, n_clr;
    logic [5:0]      r_kw_count, r_end_col;
    logic [2:0]      r_scan, n_scan;
    logic [1:0]      r_run, n_run;
    logic [TLW-1:0]  r_tlen, n_tlen;
    logic [7:0]      r_text [MAX_TOKEN];
    logic [4:0]      r_klen [KEY_SLOTS];
    logic [7:0]      r_ch, n_ch;
    logic [7:0]      r_attr, n_attr;
    logic [2:0]      r_cls, n_cls;
    logic            r_after_char, n_after_char;
    logic [5:0]      r_kslot, n_kslot;
    logic [TLW-1:0]  r_pos, n_pos;
    logic [2:0]      r_tok_cls, n_tok_cls;
    logic            r_out_valid, n_out_valid;
    logic [2:0]      r_out_cls, n_out_cls;
    logic [7:0]      r_out_char, n_out_char;
    logic            r_out_last, n_out_last;

    logic            w_out_free;
    logic            w_accept;
    logic            w_text_we;
    logic            w_t_we, w_a_we, w_k_we;
    logic [TAW-1:0]  w_t_waddr, w_t_raddr;
    logic [2:0]      w_t_wdata, w_t_rdata;
    logic [7:0]      w_a_waddr, w_a_wdata, w_a_rdata;
    logic [KAW-1:0]  w_k_waddr, w_k_raddr;
    logic [7:0]      w_k_rdata;
    logic [5:0]      w_kw_limit;
    logic [7:0]      w_text_rd;
    logic [2:0]      w_cls;
    logic            w_cfg_we;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;
    assign prdata   = (paddr[2] == tdl_pkg::REG_END_COL) ? {26'd0, r_end_col}
                                                         : {26'd0, r_kw_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_count <= '0;
            r_end_col  <= '0;
        end else if (w_cfg_we) begin
            if (paddr[2] == tdl_pkg::REG_KW_COUNT) begin
                r_kw_count <= pwdata[5:0];
            end else begin
                r_end_col <= pwdata[5:0];
            end
        end
    end

    assign w_kw_limit = ({1'b0, r_kw_count} > 7'(KEY_SLOTS)) ? 6'(KEY_SLOTS) : r_kw_count;

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    tdl_ram #(.WIDTH(3), .DEPTH(TDEPTH)) u_trans (
        .i_clk, .i_we(w_t_we), .i_waddr(w_t_waddr), .i_wdata(w_t_wdata),
        .i_raddr(w_t_raddr), .o_rdata(w_t_rdata)
    );

    tdl_ram #(.WIDTH(8), .DEPTH(256)) u_attr (
        .i_clk, .i_we(w_a_we), .i_waddr(w_a_waddr), .i_wdata(w_a_wdata),
        .i_raddr(i_char_code), .o_rdata(w_a_rdata)
    );

    tdl_ram #(.WIDTH(8), .DEPTH(KDEPTH)) u_kw (
        .i_clk, .i_we(w_k_we), .i_waddr(w_k_waddr), .i_wdata(i_char_code),
        .i_raddr(w_k_raddr), .o_rdata(w_k_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_text_rd  = r_text[r_pos[TIW-1:0]];

    // RAM write ports: clearing pass, else load items
    always_comb begin
        w_t_we    = 1'b0;
        w_t_waddr = TAW'(r_clr);
        w_t_wdata = '0;
        w_a_we    = 1'b0;
        w_a_waddr = r_clr[7:0];
        w_a_wdata = '0;
        w_k_we    = 1'b0;
        w_k_waddr = KAW'(32'(i_keyword_slot) * tdl_pkg::KEY_LEN + 32'(i_keyword_pos));
        if (r_state == S_CLEAR) begin
            w_t_we = (32'(r_clr) < TDEPTH);
            w_a_we = (32'(r_clr) < 256);
        end else if (w_accept) begin
            w_t_waddr = TAW'(32'(i_table_row) * COLUMNS + 32'(i_table_column));
            w_t_wdata = i_table_next;
            w_t_we    = (i_opcode == tdl_pkg::OP_TRANS) && (32'(i_table_row) < STATES)
                        && (32'(i_table_column) < COLUMNS);
            w_a_waddr = i_char_code;
            w_a_wdata = {i_char_kind, i_table_column};
            w_a_we    = (i_opcode == tdl_pkg::OP_ATTR);
            w_k_we    = (i_opcode == tdl_pkg::OP_KEYWORD)
                        && (32'(i_keyword_slot) < KEY_SLOTS);
        end
    end

    // transition read: end-symbol lookup on close, DFA step otherwise
    assign w_t_raddr = (r_state == S_CLOSE)
                       ? TAW'(32'(r_scan) * COLUMNS + 32'(r_end_col))
                       : TAW'(32'(r_scan) * COLUMNS + 32'(r_attr[5:0]));
    assign w_k_raddr = KAW'(32'(n_kslot) * tdl_pkg::KEY_LEN + 32'(n_pos));

    // classify the character just read
    always_comb begin
        if (r_ch == tdl_pkg::CH_SPACE) begin
            w_cls = tdl_pkg::CL_SEP;
        end else if (w_a_rdata[7:6] == tdl_pkg::KIND_SPECIAL) begin
            w_cls = tdl_pkg::CL_SPECIAL;
        end else if (w_a_rdata[7:6] == tdl_pkg::KIND_LIMITER) begin
            w_cls = tdl_pkg::CL_LIMITER;
        end else if (r_ch >= tdl_pkg::CH_ZERO && r_ch <= tdl_pkg::CH_NINE) begin
            w_cls = tdl_pkg::CL_DIGIT;
        end else if (r_ch >= tdl_pkg::CH_LOW_A && r_ch <= tdl_pkg::CH_LOW_Z) begin
            w_cls = tdl_pkg::CL_LETTER;
        end else begin
            w_cls = tdl_pkg::CL_SEP;
        end
    end

    // ------------------------------------------------------------------
    // sequencer next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_scan       = r_scan;
        n_run        = r_run;
        n_tlen       = r_tlen;
        n_ch         = r_ch;
        n_attr       = r_attr;
        n_cls        = r_cls;
        n_after_char = r_after_char;
        n_kslot      = r_kslot;
        n_pos        = r_pos;
        n_tok_cls    = r_tok_cls;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_cls    = r_out_cls;
        n_out_char   = r_out_char;
        n_out_last   = r_out_last;
        w_text_we    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (32'(r_clr) == CLEN - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_ch = i_char_code;
                    if (i_opcode == tdl_pkg::OP_CHAR) begin
                        n_state = S_ATTR;
                    end else if (i_opcode == tdl_pkg::OP_EOL) begin
                        n_after_char = 1'b0;
                        n_state      = S_CLOSE;
                    end
                end
            end
            S_ATTR: begin
                n_attr = w_a_rdata;
                n_cls  = w_cls;
                if (r_run != 2'(tdl_pkg::CL_SEP) && w_cls != {1'b0, r_run}) begin
                    n_after_char = 1'b1;
                    n_state      = S_CLOSE;
                end else begin
                    n_state = S_CHAR;
                end
            end
            S_CHAR: begin
                if (r_cls == tdl_pkg::CL_SPECIAL || r_cls == tdl_pkg::CL_LIMITER) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_out_cls   = r_cls;
                        n_out_char  = r_ch;
                        n_out_last  = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (r_cls == tdl_pkg::CL_DIGIT || r_cls == tdl_pkg::CL_LETTER) begin
                    n_run = r_cls[1:0];
                    if (32'(r_tlen) < MAX_TOKEN) begin
                        w_text_we = 1'b1;
                        n_tlen    = r_tlen + 1'b1;
                    end
                    // moves without a table entry go dead
                    if (r_scan == tdl_pkg::ST_ACCEPT || 32'(r_scan) >= STATES
                            || r_attr[7:6] != tdl_pkg::KIND_TERM
                            || 32'(r_attr[5:0]) >= COLUMNS) begin
                        n_scan  = tdl_pkg::ST_DEAD;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_STEP;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_STEP: begin
                n_scan  = w_t_rdata;
                n_state = S_IDLE;
            end
            S_CLOSE: begin
                if (r_run == 2'(tdl_pkg::CL_SEP)) begin
                    n_state = r_after_char ? S_CHAR : S_IDLE;
                end else if (r_scan == tdl_pkg::ST_ACCEPT) begin
                    n_kslot   = '0;
                    n_pos     = '0;
                    n_tok_cls = tdl_pkg::TK_CONST;
                    n_state   = (r_run == 2'(tdl_pkg::CL_DIGIT)) ? S_EMIT : S_KW_SLOT;
                end else if (32'(r_scan) >= STATES || 32'(r_end_col) >= COLUMNS) begin
                    n_run   = '0;
                    n_tlen  = '0;
                    n_scan  = '0;
                    n_state = r_after_char ? S_CHAR : S_IDLE;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (w_t_rdata == tdl_pkg::ST_ACCEPT) begin
                    n_kslot   = '0;
                    n_pos     = '0;
                    n_tok_cls = tdl_pkg::TK_CONST;
                    n_state   = (r_run == 2'(tdl_pkg::CL_DIGIT)) ? S_EMIT : S_KW_SLOT;
                end else begin
                    n_run   = '0;
                    n_tlen  = '0;
                    n_scan  = '0;
                    n_state = r_after_char ? S_CHAR : S_IDLE;
                end
            end
            S_KW_SLOT: begin
                if (r_kslot >= w_kw_limit) begin
                    n_tok_cls = tdl_pkg::TK_IDENT;
                    n_pos     = '0;
                    n_state   = S_EMIT;
                end else if (6'(r_klen[r_kslot[KIW-1:0]]) != 6'(r_tlen)) begin
                    n_kslot = r_kslot + 1'b1;
                end else begin
                    n_pos   = '0;
                    n_state = S_KW_CMP;
                end
            end
            S_KW_CMP: begin
                if (w_k_rdata != w_text_rd) begin
                    n_kslot = r_kslot + 1'b1;
                    n_pos   = '0;
                    n_state = S_KW_SLOT;
                end else if (r_pos + 1'b1 == r_tlen) begin
                    n_tok_cls = tdl_pkg::TK_KEYWORD;
                    n_pos     = '0;
                    n_state   = S_EMIT;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cls   = r_tok_cls;
                    n_out_char  = w_text_rd;
                    n_out_last  = (r_pos + 1'b1 == r_tlen);
                    n_pos       = r_pos + 1'b1;
                    if (r_pos + 1'b1 == r_tlen) begin
                        n_run   = '0;
                        n_tlen  = '0;
                        n_scan  = '0;
                        n_state = r_after_char ? S_CHAR : S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // state and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_scan      <= '0;
            r_run       <= '0;
            r_tlen      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                r_klen[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_scan      <= n_scan;
            r_run       <= n_run;
            r_tlen      <= n_tlen;
            r_out_valid <= n_out_valid;
            if (w_k_we && i_keyword_end) begin
                r_klen[i_keyword_slot[KIW-1:0]] <= 5'(i_keyword_pos) + 5'd1;
            end
        end
        r_ch         <= n_ch;
        r_attr       <= n_attr;
        r_cls        <= n_cls;
        r_after_char <= n_after_char;
        r_kslot      <= n_kslot;
        r_pos        <= n_pos;
        r_tok_cls    <= n_tok_cls;
        r_out_cls    <= n_out_cls;
        r_out_char   <= n_out_char;
        r_out_last   <= n_out_last;
        if (w_text_we) begin
            r_text[r_tlen[TIW-1:0]] <= r_ch;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_token_class = r_out_cls;
    assign o_token_char  = r_out_char;
    assign o_token_last  = r_out_last;

`ifndef SYNTHESIS
    a_tlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_tlen) <= MAX_TOKEN)
        else $error("token length above limit");
    a_no_run_no_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run == 2'd0) |-> (r_tlen == '0))
        else $error("text held without a pending run");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_tlen != '0))
        else $error("emitting an empty token");
    a_char_reads_attr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_opcode == tdl_pkg::OP_CHAR) |=> (r_state == S_ATTR))
        else $error("source item did not start an attribute read");
`endif

endmodule

FILE: hdl/tdl_ram.sv
// ----------------------------------------------------------------------------
// tdl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
